// ===== design/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

	localparam int PERIOD_W  = 24;
	localparam int TWIDTH_W  = 8;
	localparam int TIMEOUT_W = 16;
	localparam int SCALE_W   = 16;
	localparam int ECHO_CNT_W = 17;
	localparam int DIST_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 24;

	localparam int SCALE_FRAC_BITS_DEF = 16;

	localparam logic [PERIOD_W-1:0]   PING_PERIOD_RST  = 24'd200000;
	localparam logic [TWIDTH_W-1:0]   TRIG_WIDTH_RST   = 8'd10;
	localparam logic [TIMEOUT_W-1:0]  ECHO_TIMEOUT_RST = 16'd38000;
	localparam logic [SCALE_W-1:0]    CM_SCALE_RST     = 16'd1124;

	localparam logic [ECHO_CNT_W-1:0] ECHO_CNT_MAX = {ECHO_CNT_W{1'b1}};
	localparam logic [PERIOD_W-1:0]   PERIOD_MAX   = {PERIOD_W{1'b1}};
	localparam logic [DIST_W-1:0]     DIST_MAX     = {DIST_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PING_PERIOD  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_WIDTH   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CM_SCALE     = 8'd3;

	typedef enum logic [STATUS_W-1:0] {
		STAT_NONE    = 2'd0,
		STAT_NEW     = 2'd1,
		STAT_TIMEOUT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_TRIG   = 3'd1,
		PH_WAIT   = 3'd2,
		PH_ECHO   = 3'd3,
		PH_DONE   = 3'd4,
		PH_NOECHO = 3'd5
	} phase_t;

	typedef struct packed {
		logic [PERIOD_W-1:0]  ping_period;
		logic [TWIDTH_W-1:0]  trig_width;
		logic [TIMEOUT_W-1:0] echo_timeout;
		logic [SCALE_W-1:0]   cm_scale;
	} cfg_t;

	typedef struct packed {
		logic               trig;
		logic [DIST_W-1:0]  distance;
		status_t            status;
	} res_t;

endpackage

// ===== design/uer_scale.sv =====
// ----------------------------------------------------------------------------
// uer_scale
// Echo width to centimetres: fixed-point multiply, truncate, saturate.
// ----------------------------------------------------------------------------
module uer_scale #(
	parameter int SCALE_FRAC_BITS = uer_pkg::SCALE_FRAC_BITS_DEF
) (
	input  logic [uer_pkg::ECHO_CNT_W-1:0] width,
	input  logic [uer_pkg::SCALE_W-1:0]    scale,
	output logic [uer_pkg::DIST_W-1:0]     cm
);
	import uer_pkg::*;

	localparam int PROD_W = ECHO_CNT_W + SCALE_W;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] shifted;

	assign prod    = {{SCALE_W{1'b0}}, width} * {{ECHO_CNT_W{1'b0}}, scale};
	assign shifted = prod >> SCALE_FRAC_BITS;
	assign cm      = (|shifted[PROD_W-1:DIST_W]) ? DIST_MAX : shifted[DIST_W-1:0];

endmodule

// ===== design/uer_ctrl.sv =====
// ----------------------------------------------------------------------------
// uer_ctrl
// Ping timing, echo edge tracking and width counting, one tick per step.
// ----------------------------------------------------------------------------
module uer_ctrl #(
	parameter int SCALE_FRAC_BITS = uer_pkg::SCALE_FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          echo,
	input  uer_pkg::cfg_t cfg,
	output uer_pkg::res_t res
);
	import uer_pkg::*;

	phase_t                phase_q, phase_d;
	logic [PERIOD_W-1:0]   period_cnt_q, period_cnt_d;
	logic [TWIDTH_W-1:0]   trig_cnt_q, trig_cnt_d;
	logic [ECHO_CNT_W-1:0] echo_cnt_q, echo_cnt_d;
	logic                  echo_prev_q;
	logic [DIST_W-1:0]     dist_q, dist_d;

	logic [PERIOD_W:0]     pc_sum;
	logic [PERIOD_W-1:0]   pc;
	logic [PERIOD_W-1:0]   period;
	logic [TWIDTH_W-1:0]   twidth;
	logic                  ping_start;
	phase_t                phase_eff;
	logic [TWIDTH_W-1:0]   trig_cnt_eff;
	logic [TWIDTH_W-1:0]   trig_cnt_inc;
	logic [ECHO_CNT_W-1:0] echo_cnt_inc;
	logic                  rise;
	logic                  fall;
	logic                  timed_out;
	logic [DIST_W-1:0]     cm;

	// shared decode of this tick
	always_comb begin
		pc_sum       = {1'b0, period_cnt_q} + {{PERIOD_W{1'b0}}, 1'b1};
		pc           = pc_sum[PERIOD_W] ? PERIOD_MAX : pc_sum[PERIOD_W-1:0];
		period       = (cfg.ping_period == '0) ? {{(PERIOD_W-1){1'b0}}, 1'b1}
		                                       : cfg.ping_period;
		twidth       = (cfg.trig_width == '0) ? {{(TWIDTH_W-1){1'b0}}, 1'b1}
		                                      : cfg.trig_width;
		ping_start   = (pc >= period);
		phase_eff    = ping_start ? PH_TRIG : phase_q;
		trig_cnt_eff = ping_start ? '0 : trig_cnt_q;
		trig_cnt_inc = trig_cnt_eff + {{(TWIDTH_W-1){1'b0}}, 1'b1};
		echo_cnt_inc = (echo_cnt_q < ECHO_CNT_MAX)
		             ? echo_cnt_q + {{(ECHO_CNT_W-1){1'b0}}, 1'b1} : echo_cnt_q;
		rise         = echo && !echo_prev_q;
		fall         = !echo && echo_prev_q;
		timed_out    = echo_cnt_inc > {{(ECHO_CNT_W-TIMEOUT_W){1'b0}}, cfg.echo_timeout};
	end

	uer_scale #(
		.SCALE_FRAC_BITS(SCALE_FRAC_BITS)
	) u_scale (
		.width(echo_cnt_inc),
		.scale(cfg.cm_scale),
		.cm   (cm)
	);

	// next state
	always_comb begin
		phase_d      = phase_eff;
		period_cnt_d = ping_start ? '0 : pc;
		trig_cnt_d   = trig_cnt_eff;
		echo_cnt_d   = echo_cnt_q;
		dist_d       = dist_q;
		case (phase_eff)
			PH_TRIG: begin
				trig_cnt_d = trig_cnt_inc;
				if (trig_cnt_inc >= twidth) begin
					phase_d = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (rise) begin
					phase_d    = PH_ECHO;
					echo_cnt_d = '0;
				end
			end
			PH_ECHO: begin
				echo_cnt_d = echo_cnt_inc;
				if (fall) begin
					phase_d = PH_DONE;
					dist_d  = cm;
				end else if (timed_out) begin
					phase_d = PH_NOECHO;
					dist_d  = DIST_MAX;
				end
			end
			default: begin
			end
		endcase
	end

	// result of this tick
	always_comb begin
		res.trig     = 1'b0;
		res.distance = dist_d;
		res.status   = STAT_NONE;
		case (phase_eff)
			PH_TRIG: begin
				res.trig = 1'b1;
			end
			PH_ECHO: begin
				if (fall) begin
					res.status = STAT_NEW;
				end else if (timed_out) begin
					res.status = STAT_TIMEOUT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			period_cnt_q <= '0;
			trig_cnt_q   <= '0;
			echo_cnt_q   <= '0;
			echo_prev_q  <= 1'b0;
			dist_q       <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			period_cnt_q <= period_cnt_d;
			trig_cnt_q   <= trig_cnt_d;
			echo_cnt_q   <= echo_cnt_d;
			echo_prev_q  <= echo;
			dist_q       <= dist_d;
		end
	end

`ifndef SYNTH
	a_status_from_echo: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.status != STAT_NONE |-> phase_q == PH_ECHO && !ping_start)
		else $error("status reported outside echo measurement");

	a_new_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.status == STAT_NEW |=> phase_q == PH_DONE)
		else $error("new distance did not end measurement");

	a_trig_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.trig |=> phase_q == PH_TRIG || phase_q == PH_WAIT)
		else $error("trigger tick left an unexpected phase");

	a_period_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> period_cnt_q < $past(period))
		else $error("period counter ran past the ping period");
`endif

endmodule

// ===== design/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Trigger and echo timing for an ultrasonic ranging sensor, one item per
// microsecond tick, with distance conversion and no-echo detection.
//
//   channel  direction  handshake                  payload
//   sample   in         sample_valid/sample_stall  echo_level
//   result   out        result_valid/result_stall  trigger_level, distance_cm, status
//   cfg      in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// one item per cycle sustained while the result is not stalled; each item passes
// the input register, then the result register after the timing logic and multiply
// reset returns configuration to defaults and the ranger to idle, no ping sent
// a stalled result holds the result register; the input register keeps taking
// items until it too is full, then sample_stall rises
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
	parameter int SCALE_FRAC_BITS = uer_pkg::SCALE_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic                           echo_level,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           trigger_level,
	output logic [uer_pkg::DIST_W-1:0]     distance_cm,
	output logic [uer_pkg::STATUS_W-1:0]   status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
	import uer_pkg::*;

	cfg_t              cfg_q;
	logic              valid_s1;
	logic              echo_s1;
	logic              advance;
	logic              step;
	res_t              res;
	logic              result_valid_q;
	logic              trigger_level_q;
	logic [DIST_W-1:0] distance_cm_q;
	status_t           status_q;

	assign cfg_ready    = 1'b1;
	assign advance      = !result_valid_q || !result_stall;
	assign step         = valid_s1 && advance;
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ping_period  <= PING_PERIOD_RST;
			cfg_q.trig_width   <= TRIG_WIDTH_RST;
			cfg_q.echo_timeout <= ECHO_TIMEOUT_RST;
			cfg_q.cm_scale     <= CM_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PING_PERIOD:  cfg_q.ping_period  <= cfg_data[PERIOD_W-1:0];
				REG_TRIG_WIDTH:   cfg_q.trig_width   <= cfg_data[TWIDTH_W-1:0];
				REG_ECHO_TIMEOUT: cfg_q.echo_timeout <= cfg_data[TIMEOUT_W-1:0];
				REG_CM_SCALE:     cfg_q.cm_scale     <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			echo_s1 <= echo_level;
		end
	end

	uer_ctrl #(
		.SCALE_FRAC_BITS(SCALE_FRAC_BITS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.echo  (echo_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			trigger_level_q <= res.trig;
			distance_cm_q   <= res.distance;
			status_q        <= res.status;
		end
	end

	assign result_valid  = result_valid_q;
	assign trigger_level = trigger_level_q;
	assign distance_cm   = distance_cm_q;
	assign status        = status_q;

`ifndef SYNTH
	a_timeout_dist: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == STAT_TIMEOUT |-> distance_cm == DIST_MAX)
		else $error("timeout item without saturated distance");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && result_valid_q && result_stall)
		else $error("input stalled with room downstream");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			status == STAT_NONE || status == STAT_NEW || status == STAT_TIMEOUT)
		else $error("undefined status code");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ultrasonic echo ranger. Microsecond ticks carry
// echo pulses shaped around the ranger's wait and count windows. The register
// settings span the extremes, and two long pulses cover a saturated distance
// and a late timeout. Every result tick is predicted and compared field
// by field.
// ----------------------------------------------------------------------------
module tb_top;
	import uer_pkg::*;

	localparam int SETTLE_CYCLES = 6;
	localparam int STUCK_LIMIT = 1000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  echo;
		logic                  pinned;
		res_t                  res;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	logic                  echo_level = 1'b0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic                  trigger_level;
	logic [DIST_W-1:0]     distance_cm;
	logic [STATUS_W-1:0]   status;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// ranger state as predicted
	cfg_t                  cfg_shadow;
	phase_t                ph;
	logic [PERIOD_W-1:0]   period_cnt;
	logic [TWIDTH_W-1:0]   trig_cnt;
	logic [ECHO_CNT_W-1:0] echo_cnt;
	logic                  echo_last;
	logic [DIST_W-1:0]     range_cm;
	res_t                  pending_readings [$];

	logic row_pinned = 1'b0;
	res_t row_expect = '0;
	bit   steady = 1'b0;
	bit   sample_took = 1'b0;
	bit   cfg_took = 1'b0;
	int   stuck = 0;
	int   failures = 0;
	int   ticks_sent = 0;
	int   readings_checked = 0;
	int   distances_seen = 0;
	int   no_echo_seen = 0;
	int   reg_writes = 0;

	row_t script [$];

	ultrasonic_echo_ranger dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.echo_level   (echo_level),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.trigger_level(trigger_level),
		.distance_cm  (distance_cm),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic res_t next_reading(input logic echo);
		logic [PERIOD_W:0]             pc;
		logic [PERIOD_W-1:0]           per;
		logic [TWIDTH_W-1:0]           tw;
		logic [ECHO_CNT_W+SCALE_W-1:0] prod;
		logic                          rise;
		logic                          fall;
		res_t                          r;
		per = cfg_shadow.ping_period;
		if (per == '0) per = PERIOD_W'(1);
		tw = cfg_shadow.trig_width;
		if (tw == '0) tw = TWIDTH_W'(1);
		pc = {1'b0, period_cnt} + 1'b1;
		if (pc > {1'b0, PERIOD_MAX}) pc = {1'b0, PERIOD_MAX};
		rise = echo && !echo_last;
		fall = !echo && echo_last;
		r.trig = 1'b0;
		r.status = STAT_NONE;
		if (pc >= {1'b0, per}) begin
			period_cnt = '0;
			ph = PH_TRIG;
			trig_cnt = '0;
		end else begin
			period_cnt = pc[PERIOD_W-1:0];
		end
		case (ph)
			PH_TRIG: begin
				r.trig = 1'b1;
				trig_cnt = trig_cnt + 1'b1;
				if (trig_cnt >= tw) ph = PH_WAIT;
			end
			PH_WAIT: begin
				if (rise) begin
					ph = PH_ECHO;
					echo_cnt = '0;
				end
			end
			PH_ECHO: begin
				if (echo_cnt != ECHO_CNT_MAX) echo_cnt = echo_cnt + 1'b1;
				if (fall) begin
					prod = ({{SCALE_W{1'b0}}, echo_cnt}
						* {{ECHO_CNT_W{1'b0}}, cfg_shadow.cm_scale}) >> SCALE_FRAC_BITS_DEF;
					range_cm = (prod > DIST_MAX) ? DIST_MAX : prod[DIST_W-1:0];
					r.status = STAT_NEW;
					ph = PH_DONE;
				end else if (echo_cnt > cfg_shadow.echo_timeout) begin
					range_cm = DIST_MAX;
					r.status = STAT_TIMEOUT;
					ph = PH_NOECHO;
				end
			end
			default: ;
		endcase
		echo_last = echo;
		r.distance = range_cm;
		return r;
	endfunction

	always @(posedge clk) begin : monitor
		res_t want;
		bit   progress;
		sample_took = 1'b0;
		cfg_took = 1'b0;
		progress = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PING_PERIOD:  cfg_shadow.ping_period = cfg_data[PERIOD_W-1:0];
					REG_TRIG_WIDTH:   cfg_shadow.trig_width = cfg_data[TWIDTH_W-1:0];
					REG_ECHO_TIMEOUT: cfg_shadow.echo_timeout = cfg_data[TIMEOUT_W-1:0];
					REG_CM_SCALE:     cfg_shadow.cm_scale = cfg_data[SCALE_W-1:0];
					default: ;
				endcase
				cfg_took = 1'b1;
				progress = 1'b1;
				reg_writes++;
			end
			if (sample_valid && !sample_stall) begin
				want = next_reading(echo_level);
				if (row_pinned) want = row_expect;
				pending_readings.push_back(want);
				sample_took = 1'b1;
				progress = 1'b1;
				ticks_sent++;
			end
			if (result_valid && !result_stall) begin
				progress = 1'b1;
				if (pending_readings.size() == 0) begin
					$error("unexpected item: trigger_level %0d distance_cm %0d status %0d",
						trigger_level, distance_cm, status);
					failures++;
				end else begin
					want = pending_readings.pop_front();
					readings_checked++;
					if (want.status == STAT_NEW) distances_seen++;
					if (want.status == STAT_TIMEOUT) no_echo_seen++;
					if (trigger_level !== want.trig) begin
						$error("trigger_level: expected %0d, got %0d", want.trig, trigger_level);
						failures++;
					end
					if (distance_cm !== want.distance) begin
						$error("distance_cm: expected %0d, got %0d", want.distance, distance_cm);
						failures++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						failures++;
					end
				end
			end
			stuck = progress ? 0 : stuck + 1;
		end
	end

	always @(negedge clk) begin
		result_stall <= !steady && ($urandom_range(0, 99) < 7);
	end

	initial begin : watchdog
		@(posedge arst_n);
		while (stuck < STUCK_LIMIT) @(negedge clk);
		$error("no item moved for %0d cycles", STUCK_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	task automatic send_tick(input logic e, input logic pin, input res_t pin_res);
		while (!steady && $urandom_range(0, 99) < 7) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		echo_level <= e;
		row_pinned <= pin;
		row_expect <= pin_res;
		@(negedge clk);
		while (!sample_took) @(negedge clk);
	endtask

	task automatic send_level(input logic e, input int n);
		repeat (n) send_tick(e, 1'b0, '0);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		@(negedge clk);
		while (pending_readings.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_took) @(negedge clk);
	endtask

	task automatic apply_setting(input logic [PERIOD_W-1:0] per, input logic [TWIDTH_W-1:0] tw,
			input logic [TIMEOUT_W-1:0] to, input logic [SCALE_W-1:0] sc, input bit junk_on);
		logic [CFG_DATA_W-1:0] junk;
		junk = junk_on ? CFG_DATA_W'($urandom) : '0;
		drain();
		write_reg(REG_PING_PERIOD, per);
		write_reg(REG_TRIG_WIDTH, {junk[CFG_DATA_W-1:TWIDTH_W], tw});
		write_reg(REG_ECHO_TIMEOUT, {junk[CFG_DATA_W-1:TIMEOUT_W], to});
		write_reg(REG_CM_SCALE, {junk[CFG_DATA_W-1:SCALE_W], sc});
		cfg_valid <= 1'b0;
	endtask

	// zero period forces a ping on the next tick, then the period is parked at max
	task automatic ping_once();
		drain();
		write_reg(REG_PING_PERIOD, '0);
		cfg_valid <= 1'b0;
		send_level(1'b0, 1);
		drain();
		write_reg(REG_PING_PERIOD, PERIOD_MAX);
		cfg_valid <= 1'b0;
	endtask

	// echo pulses launched while the ranger waits, widths from short to past the timeout, plus noise
	task automatic run_pulses(input int n);
		int   high_left;
		int   w;
		int   to;
		logic e;
		high_left = 0;
		to = cfg_shadow.echo_timeout;
		repeat (n) begin
			if (high_left > 0) begin
				e = 1'b1;
				high_left--;
			end else if (ph == PH_WAIT && $urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: w = $urandom_range(1, 4);
					1: w = $urandom_range(to, to + 2);
					2: w = $urandom_range(1, to);
					default: w = $urandom_range(to + 3, to + 12);
				endcase
				e = 1'b1;
				high_left = w - 1;
			end else begin
				e = 1'b0;
			end
			if ($urandom_range(0, 99) < 6) e = !e;
			send_tick(e, 1'b0, '0);
		end
	endtask

	function automatic row_t tick_row(input logic e);
		row_t r;
		r = '0;
		r.kind = ROW_TICK;
		r.echo = e;
		return r;
	endfunction

	function automatic row_t pinned_row(input logic e, input logic tr,
			input logic [DIST_W-1:0] d, input status_t st);
		row_t r;
		r = tick_row(e);
		r.pinned = 1'b1;
		r.res.trig = tr;
		r.res.distance = d;
		r.res.status = st;
		return r;
	endfunction

	function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] i,
			input logic [CFG_DATA_W-1:0] v);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = i;
		r.data = v;
		return r;
	endfunction

	initial begin : stimulus
		bit                  cfg_open;
		logic [PERIOD_W-1:0] per;
		logic [TWIDTH_W-1:0] tw;
		cfg_shadow = {PING_PERIOD_RST, TRIG_WIDTH_RST, ECHO_TIMEOUT_RST, CM_SCALE_RST};
		ph = PH_IDLE;
		period_cnt = '0;
		trig_cnt = '0;
		echo_cnt = '0;
		echo_last = 1'b0;
		range_cm = '0;
		script = '{
			pinned_row(1'b1, 1'b0, 8'd0, STAT_NONE),
			pinned_row(1'b0, 1'b0, 8'd0, STAT_NONE),
			reg_row(REG_PING_PERIOD, 24'd0),
			reg_row(REG_TRIG_WIDTH, 24'd0),
			pinned_row(1'b1, 1'b1, 8'd0, STAT_NONE),
			pinned_row(1'b0, 1'b1, 8'd0, STAT_NONE),
			reg_row(REG_UNUSED, 24'hFFFFFF),
			reg_row(REG_PING_PERIOD, 24'd6),
			reg_row(REG_TRIG_WIDTH, 24'd1),
			reg_row(REG_ECHO_TIMEOUT, 24'd1),
			reg_row(REG_CM_SCALE, 24'd65535),
			tick_row(1'b1),
			tick_row(1'b1),
			pinned_row(1'b1, 1'b0, DIST_MAX, STAT_TIMEOUT),
			tick_row(1'b0),
			tick_row(1'b0),
			tick_row(1'b1),
			tick_row(1'b1),
			tick_row(1'b0),
			tick_row(1'b1),
			tick_row(1'b1),
			tick_row(1'b0),
			tick_row(1'b0)
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		cfg_open = 1'b0;
		foreach (script[k]) begin
			if (script[k].kind == ROW_CFG) begin
				if (!cfg_open) drain();
				write_reg(script[k].idx, script[k].data);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) cfg_valid <= 1'b0;
				cfg_open = 1'b0;
				send_tick(script[k].echo, script[k].pinned, script[k].res);
			end
		end

		apply_setting(24'd40, 8'd3, 16'd20, CM_SCALE_RST, 1'b1);
		run_pulses(60);
		apply_setting(24'd30, 8'd1, 16'd1, 16'd65535, 1'b1);
		run_pulses(45);
		apply_setting(24'd25, 8'd255, 16'd10, 16'd0, 1'b1);
		run_pulses(20);
		apply_setting(24'd60, 8'd10, 16'd30, 16'd30000, 1'b0);
		steady <= 1'b1;
		run_pulses(120);
		steady <= 1'b0;
		apply_setting(24'd340, 8'd5, 16'd300, 16'd65535, 1'b1);
		run_pulses(120);
		for (int p = 0; p < 4; p++) begin
			per = PERIOD_W'($urandom_range(20, 60));
			tw = TWIDTH_W'($urandom_range(1, 8));
			apply_setting(per, tw, TIMEOUT_W'($urandom_range(1, per - tw - 4)),
				SCALE_W'($urandom_range(0, 65535)), 1'b1);
			run_pulses(40);
		end

		// long pulses: one saturated distance, then a late timeout
		steady <= 1'b1;
		apply_setting(PERIOD_MAX, 8'd1, 16'd270, 16'd65535, 1'b0);
		ping_once();
		send_level(1'b0, 3);
		send_level(1'b1, 260);
		send_level(1'b0, 3);
		apply_setting(PERIOD_MAX, 8'd1, 16'd30, CM_SCALE_RST, 1'b0);
		ping_once();
		send_level(1'b0, 2);
		send_level(1'b1, 35);
		send_level(1'b0, 3);
		steady <= 1'b0;

		drain();
		$display("ran %0d ticks through %0d register writes, %0d results checked",
			ticks_sent, reg_writes, readings_checked);
		$display("measured %0d distances and %0d no-echo reports", distances_seen, no_echo_seen);
		if (failures == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
